// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gyf_pkg.sv =====
// Package of the gyro yaw frame parser: constants, types and the angle conversion.
package gyf_pkg;

  localparam int FrameLen  = 11;
  localparam int NumCells  = FrameLen - 1;
  localparam int ByteW     = 8;
  localparam int RawW      = 16;
  localparam int YawW      = 9;
  localparam int CfgIdxW   = 2;

  // Window byte k sits in cell NumCells-1-k once the window holds ten bytes.
  localparam int PosHeader = NumCells - 1;
  localparam int PosKind   = NumCells - 2;
  localparam int PosAngLo  = NumCells - 7;
  localparam int PosAngHi  = NumCells - 8;
  localparam int PosMarkLo = NumCells - 9;
  localparam int PosMarkHi = NumCells - 10;

  localparam logic [ByteW-1:0] RstHeader = 8'h55;
  localparam logic [ByteW-1:0] RstKind   = 8'h53;
  localparam logic [ByteW-1:0] RstMarkLo = 8'hE1;
  localparam logic [ByteW-1:0] RstMarkHi = 8'h27;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeader  = 2'd0,
    CfgKind    = 2'd1,
    CfgMarkLo  = 2'd2,
    CfgMarkHi  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // Angle word times 180 over 32768, rounded toward zero.
  function automatic logic signed [YawW-1:0] yaw_of(input logic signed [RawW-1:0] raw);
    logic [23:0] prod;
    logic [23:0] biased;
    prod   = {{8{raw[RawW-1]}}, raw} * 24'd180;
    biased = prod + (prod[23] ? 24'd32767 : 24'd0);
    return biased[23:15];
  endfunction

endpackage

// ===== rtl/core/gyf_cell.sv =====
// One byte cell of the receive window shift chain.
module gyf_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gyf_pkg::cell_ctl_t         ctl,
  input  logic [gyf_pkg::ByteW-1:0]  din,
  input  logic                       vin,
  output logic [gyf_pkg::ByteW-1:0]  dout,
  output logic                       vout
);
  import gyf_pkg::*;

  logic [ByteW-1:0] data_r;
  logic             vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clear) begin
      vld_r <= 1'b0;
    end else if (ctl.shift) begin
      vld_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      data_r <= din;
    end
  end

  assign dout = data_r;
  assign vout = vld_r;

endmodule

// ===== rtl/core/gyro_yaw_frame_parser.sv =====
// Top level of the gyro yaw frame parser: byte window chain, frame match and result buffer.
//
// Usage: serial bytes from the gyro arrive on the in_ channel (in_valid, in_stall,
// in_rx_byte). A request is taken at a rising edge with in_valid high and in_stall low.
// The last ten bytes live in a chain of ten cells; the newest byte completes an
// eleven-byte window. When bytes 0, 1, 8 and 9 of that window match the four
// configuration registers, one result leaves on the out_ channel carrying the signed
// angle word (bytes 7:6) and the yaw in whole degrees, and the window empties.
// Otherwise the oldest byte falls off the end of the chain.
// Results go to an output register backed by one skid register, which takes a result while
// the output register still holds one, so bytes keep flowing while a result waits. The block
// takes one byte every cycle while in_stall is low; the match and the constant multiply by
// 180 both settle in the cycle that the byte is taken. in_stall rises only when both hold a
// result that the receiver has not taken, and drops the cycle after out_stall releases.
// Configuration writes on cfg_ are always ready. The user makes them while the block is
// idle; the block itself does not enforce this. Synchronous reset (rst_n low) empties the
// window and both result registers and loads the registers with 0x55, 0x53, 0xE1 and 0x27.
module gyro_yaw_frame_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gyf_pkg::ByteW-1:0]           in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [gyf_pkg::YawW-1:0]     out_yaw_degrees,
  output logic signed [gyf_pkg::RawW-1:0]     out_raw_angle,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gyf_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [gyf_pkg::ByteW-1:0]           cfg_wdata
);
  import gyf_pkg::*;

  logic [ByteW-1:0] header_r, kind_r, mark_lo_r, mark_hi_r;

  logic [ByteW-1:0] cell_d [NumCells+1];
  logic             cell_v [NumCells+1];
  cell_ctl_t        ctl;

  logic                    accept;
  logic                    match;
  logic signed [RawW-1:0]  raw_word;
  logic signed [YawW-1:0]  yaw_val;

  logic                    out_vld_r;
  logic signed [YawW-1:0]  out_yaw_r;
  logic signed [RawW-1:0]  out_raw_r;
  logic                    skid_vld_r;
  logic signed [YawW-1:0]  skid_yaw_r;
  logic signed [RawW-1:0]  skid_raw_r;
  logic                    out_take;

  // Configuration registers; the port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= RstHeader;
      kind_r    <= RstKind;
      mark_lo_r <= RstMarkLo;
      mark_hi_r <= RstMarkHi;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CfgHeader: header_r  <= cfg_wdata;
        CfgKind:   kind_r    <= cfg_wdata;
        CfgMarkLo: mark_lo_r <= cfg_wdata;
        CfgMarkHi: mark_hi_r <= cfg_wdata;
        default:   header_r  <= header_r;
      endcase
    end
  end

  // Byte window: the newest byte enters cell 0 and each cell passes its byte on.
  assign accept    = in_valid && !in_stall;
  assign cell_d[0] = in_rx_byte;
  assign cell_v[0] = 1'b1;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    gyf_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .din  (cell_d[i]),
      .vin  (cell_v[i]),
      .dout (cell_d[i+1]),
      .vout (cell_v[i+1])
    );
  end

  // A full chain plus the incoming byte forms a window; byte 10 is not compared.
  assign match = accept && cell_v[NumCells] &&
                 (cell_d[PosHeader+1] == header_r)  &&
                 (cell_d[PosKind+1]   == kind_r)    &&
                 (cell_d[PosMarkLo+1] == mark_lo_r) &&
                 (cell_d[PosMarkHi+1] == mark_hi_r);

  assign ctl.shift = accept;
  assign ctl.clear = match;

  assign raw_word = {cell_d[PosAngHi+1], cell_d[PosAngLo+1]};
  assign yaw_val  = yaw_of(raw_word);

  // Output register with one skid register behind it.
  assign out_take = out_vld_r && !out_stall;
  assign in_stall = skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        skid_vld_r <= 1'b0;
      end
    end else if (match) begin
      if (out_vld_r && !out_take) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_yaw_r <= skid_yaw_r;
        out_raw_r <= skid_raw_r;
      end
    end else if (match) begin
      if (out_vld_r && !out_take) begin
        skid_yaw_r <= yaw_val;
        skid_raw_r <= raw_word;
      end else begin
        out_yaw_r <= yaw_val;
        out_raw_r <= raw_word;
      end
    end
  end

  assign out_valid       = out_vld_r;
  assign out_yaw_degrees = out_yaw_r;
  assign out_raw_angle   = out_raw_r;

endmodule

// ===== rtl/core/gyf_checker.sv =====
// Port-level checker of the gyro yaw frame parser and its bind.
`include "assert_macros.svh"

module gyf_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [gyf_pkg::YawW-1:0]     out_yaw_degrees,
  input logic signed [gyf_pkg::RawW-1:0]     out_raw_angle
);
  import gyf_pkg::*;

  // Back-pressure on the input only appears with a result waiting at the output.
  `AST_IMPL(a_stall_needs_result, in_stall, out_valid, "in_stall without a pending result")

  // The yaw always agrees with the angle word it travels with.
  `AST_IMPL(a_yaw_matches_raw, out_valid, out_yaw_degrees == yaw_of(out_raw_angle),
            "yaw does not match angle word")

  // A stalled result stays in place.
  `AST_NEXT(a_out_hold, out_valid && out_stall,
            out_valid && $stable(out_raw_angle) && $stable(out_yaw_degrees),
            "stalled result changed")

  // Nothing leaves in the cycle right after reset.
  `AST_IMPL(a_reset_empty, $rose(rst_n), !out_valid && !in_stall, "result present after reset")

endmodule

bind gyro_yaw_frame_parser gyf_checker u_gyf_checker (.*);
